[rtl/skf_pkg.sv]
`timescale 1ns / 1ps

package skf_pkg;

  localparam int DATA_WIDTH = 48;
  localparam int FRAC_BITS  = 24;

  localparam int NOISE_W    = DATA_WIDTH - 1;
  localparam int GAIN_W     = FRAC_BITS + 1;
  localparam int ADD_W      = DATA_WIDTH + 2;
  localparam int CNT_W      = $clog2(FRAC_BITS + 1);
  localparam int CFG_INDEX_W = 2;

  typedef logic [1:0]                 kind_t;
  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic [NOISE_W-1:0]         noise_t;
  typedef logic [GAIN_W-1:0]          gain_t;
  typedef logic [ADD_W-1:0]           sum_t;

  localparam kind_t KIND_UPDATE = 2'd0;
  localparam kind_t KIND_CLEAR  = 2'd1;
  localparam kind_t KIND_PEEK   = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_PROCESS_NOISE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MEASURE_NOISE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_INIT_PRED     = 2'd2;

  localparam noise_t PROCESS_NOISE_RESET = NOISE_W'(16777);
  localparam noise_t MEASURE_NOISE_RESET = NOISE_W'(16777216);

  localparam logic [DATA_WIDTH-1:0] POS_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam sum_t ONE_FIX = sum_t'(1) << FRAC_BITS;

endpackage

[rtl/skf_sample_if.sv]
`timescale 1ns / 1ps

interface skf_sample_if;
  import skf_pkg::*;

  logic  valid;
  logic  ready;
  kind_t kind;
  data_t measurement;

  modport source (output valid, kind, measurement, input ready);
  modport sink (input valid, kind, measurement, output ready);
endinterface

[rtl/skf_result_if.sv]
`timescale 1ns / 1ps

interface skf_result_if;
  import skf_pkg::*;

  logic  valid;
  logic  ready;
  data_t estimate;
  logic  divide_error;

  modport source (output valid, estimate, divide_error, input ready);
  modport sink (input valid, estimate, divide_error, output ready);
endinterface

[rtl/scalar_kalman_filter.sv]
`timescale 1ns / 1ps

// Scalar Kalman filter, signed Q23.24 estimate and variance.
// sample channel: valid/ready beat with kind (update, clear, peek) and a
// measurement; every sample beat yields exactly one beat on the result
// channel with the estimate after that item and a divide error flag.
// Clear and peek finish in the accept cycle; the result is valid on the
// next cycle. An update steps through the sequencer to its result, going
// straight to the result when p+R is zero. One 50-bit adder is
// shared by a 25-step restoring divider for the gain and two 25-step
// shift-add multipliers, plus a handful of single add steps.
// Only one item is in flight; sample.ready is high when the sequencer is
// idle and the result register is empty or being drained in that cycle.
// A stalled result holds its value; a finished update waits for the
// result register before it commits state.
// cfg_write/cfg_index/cfg_data write Q, R and the initial prediction;
// writes are expected only while the block is idle.
// Synchronous reset clears estimate and variance, loads the default
// Q, R and initial prediction, and empties the result register.
module scalar_kalman_filter (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [skf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [skf_pkg::DATA_WIDTH-1:0]   cfg_data,
  skf_sample_if.sink                       sample,
  skf_result_if.source                     result
);
  import skf_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_PRED = 4'd1;
  localparam logic [3:0] ST_DEN  = 4'd2;
  localparam logic [3:0] ST_DIV  = 4'd3;
  localparam logic [3:0] ST_DIFF = 4'd4;
  localparam logic [3:0] ST_ABS  = 4'd5;
  localparam logic [3:0] ST_MUL1 = 4'd6;
  localparam logic [3:0] ST_UPD  = 4'd7;
  localparam logic [3:0] ST_CK   = 4'd8;
  localparam logic [3:0] ST_MUL2 = 4'd9;
  localparam logic [3:0] ST_DONE = 4'd10;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAC_BITS);

  logic [3:0]            state;
  noise_t                process_noise;
  noise_t                measure_noise;
  data_t                 initial_prediction;
  data_t                 estimate_reg;
  logic [DATA_WIDTH-1:0] variance_reg;

  data_t                 x;
  data_t                 meas;
  logic [DATA_WIDTH-1:0] p;
  logic [DATA_WIDTH-1:0] den;
  logic [DATA_WIDTH-1:0] rem;
  gain_t                 q;
  gain_t                 mreg;
  logic [DATA_WIDTH-1:0] mcand;
  logic [DATA_WIDTH:0]   acc;
  logic [CNT_W-1:0]      cnt;
  logic                  neg;
  logic                  err;

  logic                  out_valid;
  data_t                 out_estimate;
  logic                  out_error;

  sum_t add_a;
  sum_t add_b;
  logic add_sub;
  sum_t sum;
  logic take;
  logic drain_ok;
  logic load_out;

  assign drain_ok         = !out_valid || result.ready;
  assign sample.ready     = (state == ST_IDLE) && drain_ok;
  assign take             = sample.valid && sample.ready;
  assign load_out         = (take && (sample.kind != KIND_UPDATE)) ||
                            ((state == ST_DONE) && drain_ok);
  assign result.valid     = out_valid;
  assign result.estimate  = out_estimate;
  assign result.divide_error = out_error;

  // shared adder
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    case (state)
      ST_PRED: begin
        add_a = {2'b00, variance_reg};
        add_b = {3'b000, process_noise};
      end
      ST_DEN: begin
        add_a = {2'b00, p};
        add_b = {3'b000, measure_noise};
      end
      ST_DIV: begin
        add_a   = (cnt == '0) ? {2'b00, rem} : {1'b0, rem, 1'b0};
        add_b   = {2'b00, den};
        add_sub = 1'b1;
      end
      ST_DIFF: begin
        add_a   = {{2{meas[DATA_WIDTH-1]}}, meas};
        add_b   = {{2{x[DATA_WIDTH-1]}}, x};
        add_sub = 1'b1;
      end
      ST_ABS: begin
        add_a   = neg ? {{2{x[DATA_WIDTH-1]}}, x} : {{2{meas[DATA_WIDTH-1]}}, meas};
        add_b   = neg ? {{2{meas[DATA_WIDTH-1]}}, meas} : {{2{x[DATA_WIDTH-1]}}, x};
        add_sub = 1'b1;
      end
      ST_MUL1, ST_MUL2: begin
        add_a = {1'b0, acc};
        add_b = mreg[0] ? {2'b00, mcand} : '0;
      end
      ST_UPD: begin
        add_a   = {{2{x[DATA_WIDTH-1]}}, x};
        add_b   = {2'b00, acc[DATA_WIDTH-1:0]};
        add_sub = neg;
      end
      ST_CK: begin
        add_a   = ONE_FIX;
        add_b   = {{(ADD_W-GAIN_W){1'b0}}, q};
        add_sub = 1'b1;
      end
      default: begin
        add_a = '0;
      end
    endcase
    sum = add_a + (add_sub ? ~add_b : add_b) + ADD_W'(add_sub);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      out_valid          <= 1'b0;
      estimate_reg       <= '0;
      variance_reg       <= '0;
      process_noise      <= PROCESS_NOISE_RESET;
      measure_noise      <= MEASURE_NOISE_RESET;
      initial_prediction <= '0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end

      if (cfg_write) begin
        case (cfg_index)
          CFG_PROCESS_NOISE: process_noise <= cfg_data[NOISE_W-1:0];
          CFG_MEASURE_NOISE: measure_noise <= cfg_data[NOISE_W-1:0];
          CFG_INIT_PRED:     initial_prediction <= cfg_data;
          default: ;
        endcase
      end

      case (state)
        ST_IDLE: begin
          if (take) begin
            case (sample.kind)
              KIND_UPDATE: begin
                x     <= (estimate_reg == '0) ? initial_prediction : estimate_reg;
                meas  <= sample.measurement;
                state <= ST_PRED;
              end
              KIND_CLEAR: begin
                estimate_reg <= '0;
                variance_reg <= '0;
                out_estimate <= '0;
                out_error    <= 1'b0;
              end
              default: begin
                out_estimate <= estimate_reg;
                out_error    <= 1'b0;
              end
            endcase
          end
        end
        ST_PRED: begin
          p     <= sum[DATA_WIDTH-1] ? POS_MAX : sum[DATA_WIDTH-1:0];
          state <= ST_DEN;
        end
        ST_DEN: begin
          den <= sum[DATA_WIDTH-1:0];
          rem <= p;
          q   <= '0;
          cnt <= '0;
          if (sum[DATA_WIDTH-1:0] == '0) begin
            err   <= 1'b1;
            state <= ST_DONE;
          end else begin
            err   <= 1'b0;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          // restoring division, integer bit first
          q <= {q[GAIN_W-2:0], ~sum[ADD_W-1]};
          if (!sum[ADD_W-1]) begin
            rem <= sum[DATA_WIDTH-1:0];
          end else begin
            rem <= add_a[DATA_WIDTH-1:0];
          end
          if (cnt == CNT_LAST) begin
            state <= ST_DIFF;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_DIFF: begin
          neg   <= sum[ADD_W-1];
          state <= ST_ABS;
        end
        ST_ABS: begin
          mcand <= sum[DATA_WIDTH-1:0];
          mreg  <= q;
          acc   <= '0;
          cnt   <= '0;
          state <= ST_MUL1;
        end
        ST_MUL1, ST_MUL2: begin
          // shift-add, truncating product >> FRAC_BITS
          mreg <= mreg >> 1;
          if (cnt == CNT_LAST) begin
            acc   <= sum[DATA_WIDTH:0];
            state <= (state == ST_MUL1) ? ST_UPD : ST_DONE;
          end else begin
            acc <= sum[DATA_WIDTH+1:1];
            cnt <= cnt + 1'b1;
          end
        end
        ST_UPD: begin
          x     <= sum[DATA_WIDTH-1:0];
          state <= ST_CK;
        end
        ST_CK: begin
          mcand <= p;
          mreg  <= sum[GAIN_W-1:0];
          acc   <= '0;
          cnt   <= '0;
          state <= ST_MUL2;
        end
        ST_DONE: begin
          if (drain_ok) begin
            if (err) begin
              out_estimate <= estimate_reg;
            end else begin
              estimate_reg <= x;
              variance_reg <= acc[DATA_WIDTH-1:0];
              out_estimate <= x;
            end
            out_error <= err;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
